### hdl/kpl_pkg.sv
// shared types, constants and codes for the keypad scanner with long press
package kpl_pkg;

   // matrix geometry
   localparam int ROWS = 6;
   localparam int COLS = 7;

   // field widths
   localparam int COL_SENSE_W = 7;
   localparam int ROW_W       = 3;
   localparam int COL_W       = 3;
   localparam int KIND_W      = 3;
   localparam int CNT_W       = 8;
   localparam int DIR_W       = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

   // column lines above the matrix width read as released
   localparam logic [COL_SENSE_W-1:0] COL_PAD = ~COL_SENSE_W'((1 << COLS) - 1);
   localparam logic [COL_SENSE_W-1:0] COL_IDLE = '1;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_TICKS     = 2'd2;

   // register reset values
   localparam logic [CNT_W-1:0] LONG_THRESHOLD_RST = 8'h80;
   localparam logic [CNT_W-1:0] LOCKOUT_TICKS_RST  = 8'd100;
   localparam logic [CNT_W-1:0] BEEP_TICKS_RST     = 8'd40;

   // report kinds
   localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MATRIX     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UP_SHORT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DOWN_SHORT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UP_LONG    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DOWN_LONG  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_MUTE_LONG  = 3'd6;

   // last direction key codes
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] long_threshold;
      logic [CNT_W-1:0] lockout_ticks;
      logic [CNT_W-1:0] beep_ticks;
   } kpl_cfg_type;

   typedef struct packed {
      logic [COL_SENSE_W-1:0] col_sense;
      logic                   up_key;
      logic                   down_key;
      logic                   host_take;
   } kpl_req_type;

   typedef struct packed {
      logic                   phase;
      logic [ROW_W-1:0]       row_count;
      logic [CNT_W-1:0]       lockout_left;
      logic                   pending;
      logic [KIND_W-1:0]      report_kind;
      logic [ROW_W-1:0]       report_row;
      logic [COL_W-1:0]       report_col;
      logic [CNT_W-1:0]       dir_count;
      logic [DIR_W-1:0]       last_dir;
      logic [CNT_W-1:0]       matrix_count;
      logic [ROW_W-1:0]       held_row;
      logic [COL_SENSE_W-1:0] held_cols;
      logic [CNT_W-1:0]       beep_left;
   } kpl_state_type;

   // scan state after reset: everything clear, held lines all released
   localparam kpl_state_type STATE_RST = '{held_cols: COL_IDLE, last_dir: DIR_NONE,
                                           default: '0};

   typedef struct packed {
      logic [ROW_W-1:0]  row_drive;
      logic              event_ready;
      logic [KIND_W-1:0] event_kind;
      logic [ROW_W-1:0]  event_row;
      logic [COL_W-1:0]  event_col;
      logic              buzzer;
   } kpl_rsp_type;

endpackage

### hdl/kpl_req_if.sv
// input channel: one sampled tick of keypad lines per beat
interface kpl_req_if import kpl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COL_SENSE_W-1:0] col_sense;
   logic                   up_key;
   logic                   down_key;
   logic                   host_take;

   modport source (output valid, col_sense, up_key, down_key, host_take, input ready);
   modport sink   (input valid, col_sense, up_key, down_key, host_take, output ready);
endinterface

### hdl/kpl_rsp_if.sv
// result channel: scanner status after each tick, one beat per tick
interface kpl_rsp_if import kpl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  row_drive;
   logic              event_ready;
   logic [KIND_W-1:0] event_kind;
   logic [ROW_W-1:0]  event_row;
   logic [COL_W-1:0]  event_col;
   logic              buzzer;

   modport source (output valid, row_drive, event_ready, event_kind, event_row, event_col,
                   buzzer, input ready);
   modport sink   (input valid, row_drive, event_ready, event_kind, event_row, event_col,
                   buzzer, output ready);
endinterface

### hdl/keypad_scanner_long_press.sv
// top level: matrix keypad scanner with up/down keys and long-press reports
//
//   channel | dir | handshake     | payload
//   req_if  | in  | valid/ready   | col_sense, up_key, down_key, host_take
//   rsp_if  | out | valid/ready   | row_drive, event_ready, event_kind, event_row,
//           |     |               | event_col, buzzer
//   csr     | in  | csr_we        | csr_index, csr_wdata
//
// one beat per cycle while the result side is ready; each result is registered
// (input register, then scan logic into the result register)
// the state loop closes through kpl_scan into state_ff, so back-to-back beats chain
// synchronous reset loads STATE_RST, clears both stage valids, registers go to defaults
// a stalled result holds the input stage; req ready drops only when both stages are full
module keypad_scanner_long_press import kpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   kpl_req_if.sink               req_if,
   kpl_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   kpl_cfg_type   cfg;
   kpl_req_type   in_ff;
   logic          in_v_ff;
   kpl_state_type state_ff;
   kpl_state_type state_in;
   kpl_rsp_type   out_ff;
   kpl_rsp_type   out_in;
   logic          out_v_ff;
   logic          step_go;
   logic          reported;

   kpl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpl_scan u_scan (
      .st       (state_ff),
      .cfg      (cfg),
      .req      (in_ff),
      .nxt      (state_in),
      .rsp      (out_in),
      .reported (reported)
   );

   // stage handshakes
   assign step_go      = in_v_ff && (!out_v_ff || rsp_if.ready);
   assign req_if.ready = !in_v_ff || step_go;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            in_v_ff         <= 1'b1;
            in_ff.col_sense <= req_if.col_sense;
            in_ff.up_key    <= req_if.up_key;
            in_ff.down_key  <= req_if.down_key;
            in_ff.host_take <= req_if.host_take;
         end else if (step_go) begin
            in_v_ff <= 1'b0;
         end
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (step_go) begin
         out_v_ff <= 1'b1;
         out_ff   <= out_in;
      end else if (rsp_if.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_if.valid       = out_v_ff;
   assign rsp_if.row_drive   = out_ff.row_drive;
   assign rsp_if.event_ready = out_ff.event_ready;
   assign rsp_if.event_kind  = out_ff.event_kind;
   assign rsp_if.event_row   = out_ff.event_row;
   assign rsp_if.event_col   = out_ff.event_col;
   assign rsp_if.buzzer      = out_ff.buzzer;

   // a report leaves the report pending with a full lockout
   assert property (@(posedge clock) disable iff (reset)
      step_go && reported |=>
         state_ff.pending && state_ff.lockout_left == $past(cfg.lockout_ticks))
      else $error("report did not load pending and lockout");

   // a held input beat is not overwritten while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !step_go |=> in_v_ff && $stable(in_ff))
      else $error("input stage lost a beat");

   // only matrix reports carry a row and column
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.event_kind != KIND_MATRIX |->
         out_ff.event_row == '0 && out_ff.event_col == '0)
      else $error("row or column set on a non-matrix report");

   // no kind shows without a pending report
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_ff.event_ready |-> out_ff.event_kind == KIND_NONE)
      else $error("event kind set while idle");

endmodule

### hdl/kpl_csr.sv
// configuration registers: long threshold, lockout length, beep length
module kpl_csr import kpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output kpl_cfg_type           cfg
);

   kpl_cfg_type cfg_ff;
   kpl_cfg_type cfg_in;

   // decode the write, unknown indexes fall through
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_THRESHOLD: cfg_in.long_threshold = csr_wdata;
            CSR_LOCKOUT_TICKS:  cfg_in.lockout_ticks  = csr_wdata;
            CSR_BEEP_TICKS:     cfg_in.beep_ticks     = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_threshold <= LONG_THRESHOLD_RST;
         cfg_ff.lockout_ticks  <= LOCKOUT_TICKS_RST;
         cfg_ff.beep_ticks     <= BEEP_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/kpl_scan.sv
// one tick of the scanner: row step or key scans, report, lockout and beep
module kpl_scan import kpl_pkg::*; (
   input  kpl_state_type st,
   input  kpl_cfg_type   cfg,
   input  kpl_req_type   req,
   output kpl_state_type nxt,
   output kpl_rsp_type   rsp,
   output logic          reported
);

   logic [COL_SENSE_W-1:0] cols;
   logic [DIR_W-1:0]       which;
   logic [CNT_W-1:0]       mc_inc;
   logic [CNT_W-1:0]       dc_inc;
   logic                   found;
   logic [COL_W-1:0]       first_col;
   logic [CNT_W-1:0]       beep_load;
   logic [KIND_W-1:0]      rep_kind;
   logic [ROW_W-1:0]       rep_row;
   logic [COL_W-1:0]       rep_col;

   // first low column of the held pattern
   always_comb begin
      found     = 1'b0;
      first_col = '0;
      for (int c = COLS - 1; c >= 0; c--) begin
         if (!st.held_cols[c]) begin
            found     = 1'b1;
            first_col = COL_W'(c);
         end
      end
   end

   assign cols   = req.col_sense | COL_PAD;
   assign which  = req.up_key ? DIR_UP : DIR_DOWN;
   assign mc_inc = (st.matrix_count != CNT_MAX) ? st.matrix_count + 1'b1 : st.matrix_count;
   assign dc_inc = (st.dir_count != CNT_MAX) ? st.dir_count + 1'b1 : st.dir_count;

   // state update for the tick
   always_comb begin
      nxt       = st;
      reported  = 1'b0;
      rep_kind  = KIND_NONE;
      rep_row   = '0;
      rep_col   = '0;
      nxt.pending = st.pending & ~req.host_take;
      nxt.phase   = ~st.phase;
      if (!st.phase) begin
         // odd tick: next drive row
         nxt.row_count = (st.row_count >= ROW_LAST) ? '0 : st.row_count + 1'b1;
      end else begin
         // up/down scan
         if (nxt.lockout_left != '0) begin
            nxt.lockout_left = nxt.lockout_left - 1'b1;
         end else if (!nxt.pending) begin
            if (req.up_key || req.down_key) begin
               if (st.dir_count == '0 || st.last_dir != which) begin
                  nxt.dir_count = CNT_W'(1);
                  nxt.last_dir  = which;
               end else begin
                  nxt.dir_count = dc_inc;
               end
            end else if (st.dir_count != '0) begin
               reported = 1'b1;
               if (st.dir_count > cfg.long_threshold) begin
                  rep_kind = (st.last_dir == DIR_DOWN) ? KIND_DOWN_LONG : KIND_UP_LONG;
               end else begin
                  rep_kind = (st.last_dir == DIR_DOWN) ? KIND_DOWN_SHORT : KIND_UP_SHORT;
               end
               nxt.dir_count = '0;
            end
         end
         // matrix scan, skipped after an up/down report
         if (!reported) begin
            if (nxt.lockout_left != '0) begin
               nxt.lockout_left = nxt.lockout_left - 1'b1;
            end else if (!nxt.pending) begin
               if (cols != COL_IDLE) begin
                  nxt.matrix_count = mc_inc;
                  if (st.matrix_count == '0 || cols != st.held_cols ||
                      st.held_row != st.row_count) begin
                     nxt.matrix_count = CNT_W'(1);
                     nxt.held_row     = st.row_count;
                     nxt.held_cols    = cols;
                  end
               end else if (st.matrix_count != '0 && st.held_row == st.row_count) begin
                  nxt.matrix_count = '0;
                  // no-key cell and an empty pattern give nothing
                  if (found && !(st.held_row == ROW_LAST && first_col == COL_LAST)) begin
                     reported = 1'b1;
                     if (st.held_row == ROW_LAST && first_col == '0 &&
                         st.matrix_count > cfg.long_threshold) begin
                        rep_kind = KIND_MUTE_LONG;
                     end else begin
                        rep_kind = KIND_MATRIX;
                        rep_row  = st.held_row;
                        rep_col  = first_col;
                     end
                  end
               end
            end
         end
         // latch the report
         if (reported) begin
            nxt.pending      = 1'b1;
            nxt.lockout_left = cfg.lockout_ticks;
            nxt.report_kind  = rep_kind;
            nxt.report_row   = rep_row;
            nxt.report_col   = rep_col;
         end
      end
      // beep countdown
      beep_load     = reported ? cfg.beep_ticks : st.beep_left;
      nxt.beep_left = (beep_load != '0) ? beep_load - 1'b1 : beep_load;
   end

   // result fields, report fields masked while nothing is pending
   always_comb begin
      rsp.row_drive   = nxt.row_count;
      rsp.event_ready = nxt.pending;
      rsp.event_kind  = nxt.pending ? nxt.report_kind : KIND_NONE;
      rsp.event_row   = nxt.pending ? nxt.report_row : '0;
      rsp.event_col   = nxt.pending ? nxt.report_col : '0;
      rsp.buzzer      = (nxt.beep_left != '0);
   end

endmodule

### verif/tb_top.sv
// testbench for the keypad scanner: keypad-level stimulus, status predictor and checker
module tb_top;
   import kpl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int PRINT_LIMIT = 30;
   localparam int PHASE_TICKS = 120;
   localparam int REQ_W       = $bits(kpl_req_type);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {STROKE_UP, STROKE_DOWN, STROKE_BOTH, STROKE_MATRIX} stroke_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kpl_req_if req_if ();
   kpl_rsp_if rsp_if ();

   keypad_scanner_long_press u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // scanner state and register copies kept by the predictor
   kpl_state_type kp_state;
   kpl_cfg_type   kp_cfg;

   // statuses predicted for accepted ticks, oldest first
   kpl_rsp_type status_due[$];

   int mismatches;
   int ticks_sent;
   int reports_made;
   int csr_writes;
   int req_idle_pct;
   int rsp_stall_pct;
   int hold_req;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // a scan is skipped while locked out (eating one count) or while a report waits
   function automatic bit scan_blocked();
      if (kp_state.lockout_left != 0) begin
         kp_state.lockout_left--;
         return 1'b1;
      end
      return kp_state.pending;
   endfunction

   function automatic void post_report(input logic [KIND_W-1:0] kind,
                                       input logic [ROW_W-1:0] row,
                                       input logic [COL_W-1:0] col);
      kp_state.report_kind  = kind;
      kp_state.report_row   = row;
      kp_state.report_col   = col;
      kp_state.pending      = 1'b1;
      kp_state.lockout_left = kp_cfg.lockout_ticks;
      reports_made++;
   endfunction

   // up/down keys: count while held, report short or long on release
   function automatic bit scan_dir_keys(input logic up, input logic down);
      logic [DIR_W-1:0] which;
      if (scan_blocked())
         return 1'b0;
      if (up || down) begin
         which = up ? DIR_UP : DIR_DOWN;
         if (kp_state.dir_count == 0 || kp_state.last_dir != which) begin
            kp_state.dir_count = 1;
            kp_state.last_dir  = which;
         end else if (kp_state.dir_count != CNT_MAX) begin
            kp_state.dir_count++;
         end
         return 1'b0;
      end
      if (kp_state.dir_count == 0)
         return 1'b0;
      if (kp_state.dir_count > kp_cfg.long_threshold)
         post_report(kp_state.last_dir == DIR_DOWN ? KIND_DOWN_LONG : KIND_UP_LONG, '0, '0);
      else
         post_report(kp_state.last_dir == DIR_DOWN ? KIND_DOWN_SHORT : KIND_UP_SHORT, '0, '0);
      kp_state.dir_count = 0;
      return 1'b1;
   endfunction

   // matrix columns: count while the same lines stay low on the same row
   function automatic bit scan_columns(input logic [COL_SENSE_W-1:0] cols);
      logic [COL_SENSE_W-1:0] lines;
      int low_col;
      if (scan_blocked())
         return 1'b0;
      lines = cols | COL_PAD;
      if (lines != COL_IDLE) begin
         if (kp_state.matrix_count != CNT_MAX)
            kp_state.matrix_count++;
         if (kp_state.matrix_count == 1 || lines != kp_state.held_cols ||
             kp_state.held_row != kp_state.row_count) begin
            kp_state.matrix_count = 1;
            kp_state.held_row     = kp_state.row_count;
            kp_state.held_cols    = lines;
         end
         return 1'b0;
      end
      // released lines only count on the row that was held
      if (kp_state.matrix_count == 0 || kp_state.held_row != kp_state.row_count)
         return 1'b0;
      low_col = COLS;
      for (int i = COLS - 1; i >= 0; i--)
         if (!kp_state.held_cols[i])
            low_col = i;
      // an empty pattern or the empty cell in the corner gives nothing
      if (low_col >= COLS || (kp_state.held_row == ROW_LAST && low_col == COLS - 1)) begin
         kp_state.matrix_count = 0;
         return 1'b0;
      end
      if (kp_state.held_row == ROW_LAST && low_col == 0 &&
          kp_state.matrix_count > kp_cfg.long_threshold)
         post_report(KIND_MUTE_LONG, '0, '0);
      else
         post_report(KIND_MATRIX, kp_state.held_row, COL_W'(low_col));
      kp_state.matrix_count = 0;
      return 1'b1;
   endfunction

   // one tick: host take, phase toggle, row step or scans, beep count
   function automatic kpl_rsp_type predict_tick(input kpl_req_type beat);
      kpl_rsp_type status;
      bit reported;
      reported = 1'b0;
      if (beat.host_take)
         kp_state.pending = 1'b0;
      kp_state.phase = ~kp_state.phase;
      if (kp_state.phase) begin
         kp_state.row_count = (kp_state.row_count == ROW_LAST) ? '0 :
                              kp_state.row_count + 1'b1;
      end else begin
         reported = scan_dir_keys(beat.up_key, beat.down_key);
         if (!reported)
            reported = scan_columns(beat.col_sense);
      end
      if (reported)
         kp_state.beep_left = kp_cfg.beep_ticks;
      if (kp_state.beep_left != 0)
         kp_state.beep_left--;
      status.row_drive   = kp_state.row_count;
      status.event_ready = kp_state.pending;
      status.event_kind  = kp_state.pending ? kp_state.report_kind : KIND_NONE;
      status.event_row   = kp_state.pending ? kp_state.report_row : '0;
      status.event_col   = kp_state.pending ? kp_state.report_col : '0;
      status.buzzer      = (kp_state.beep_left != 0);
      return status;
   endfunction

   // ---------------------------------------------------------------- checker

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // every status beat is compared with the oldest prediction
   always @(posedge clock) begin
      kpl_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $error("status beat with no tick outstanding");
         end else begin
            want = status_due.pop_front();
            check_field("row_drive", want.row_drive, rsp_if.row_drive);
            check_field("event_ready", want.event_ready, rsp_if.event_ready);
            check_field("event_kind", want.event_kind, rsp_if.event_kind);
            check_field("event_row", want.event_row, rsp_if.event_row);
            check_field("event_col", want.event_col, rsp_if.event_col);
            check_field("buzzer", want.buzzer, rsp_if.buzzer);
         end
      end
   end

   // result side ready: random stalls plus a long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // offer one tick after a random gap, predict its status once taken
   task automatic send_tick(input kpl_req_type beat);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.col_sense <= beat.col_sense;
      req_if.up_key    <= beat.up_key;
      req_if.down_key  <= beat.down_key;
      req_if.host_take <= beat.host_take;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      status_due.push_back(predict_tick(beat));
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LONG_THRESHOLD: kp_cfg.long_threshold = value;
         CSR_LOCKOUT_TICKS:  kp_cfg.lockout_ticks  = value;
         CSR_BEEP_TICKS:     kp_cfg.beep_ticks     = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input logic [CNT_W-1:0] threshold, input logic [CNT_W-1:0] lockout,
                             input logic [CNT_W-1:0] beep);
      write_reg(CSR_LONG_THRESHOLD, threshold);
      write_reg(CSR_LOCKOUT_TICKS, lockout);
      write_reg(CSR_BEEP_TICKS, beep);
   endtask

   // lines a real keypad shows for the next tick; odd ticks carry noise the scan ignores
   function automatic kpl_req_type keypad_lines(input stroke_type kind, input int row,
                                                input logic [COL_SENSE_W-1:0] low_mask,
                                                input bit pressed, input int take_pct);
      kpl_req_type beat;
      beat = REQ_W'($urandom);
      if (kp_state.phase) begin
         beat.col_sense = COL_IDLE;
         beat.up_key    = 1'b0;
         beat.down_key  = 1'b0;
         if (pressed) begin
            case (kind)
               STROKE_UP:   beat.up_key = 1'b1;
               STROKE_DOWN: beat.down_key = 1'b1;
               STROKE_BOTH: begin
                  beat.up_key   = 1'b1;
                  beat.down_key = 1'b1;
               end
               STROKE_MATRIX: begin
                  if (kp_state.row_count == row)
                     beat.col_sense = ~low_mask;
               end
               default: ;
            endcase
         end
      end
      beat.host_take = ($urandom_range(99) < take_pct);
      return beat;
   endfunction

   // press a key for a number of seen scans, then release it where the scan sees it
   task automatic key_stroke(input stroke_type kind, input int row,
                             input logic [COL_SENSE_W-1:0] low_mask, input int hold_scans,
                             input int take_pct, input bit settle);
      int seen;
      bit visible;
      // let the last report go and the lockout run out
      while (settle && (kp_state.pending || kp_state.lockout_left != 0))
         send_tick(keypad_lines(kind, row, low_mask, 1'b0, take_pct));
      seen = 0;
      while (seen < hold_scans) begin
         if (kp_state.phase && (kind != STROKE_MATRIX || kp_state.row_count == row))
            seen++;
         send_tick(keypad_lines(kind, row, low_mask, 1'b1, take_pct));
      end
      do begin
         visible = kp_state.phase && (kind != STROKE_MATRIX || kp_state.row_count == row);
         send_tick(keypad_lines(kind, row, low_mask, 1'b0, take_pct));
      end while (!visible);
   endtask

   // ---------------------------------------------------------------- tests

   // register defaults: long lockout and beep after each report
   task automatic test_reset_values();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      key_stroke(STROKE_UP, 0, '0, 1, 100, 1'b1);
      key_stroke(STROKE_MATRIX, 2, 7'h10, 1, 100, 1'b1);
      key_stroke(STROKE_DOWN, 0, '0, 3, 100, 1'b1);
   endtask

   // every report kind and the corner cases of the key map
   task automatic test_report_kinds();
      kpl_req_type extreme_beat;
      set_config(8'd2, 8'd0, 8'd3);
      // spare register index is ignored
      write_reg(CSR_SPARE, 8'hFF);
      extreme_beat = '1;
      send_tick(extreme_beat);
      extreme_beat = '0;
      send_tick(extreme_beat);
      key_stroke(STROKE_UP, 0, '0, 1, 100, 1'b1);
      key_stroke(STROKE_UP, 0, '0, 3, 100, 1'b1);
      key_stroke(STROKE_DOWN, 0, '0, 2, 100, 1'b1);
      key_stroke(STROKE_DOWN, 0, '0, 4, 100, 1'b1);
      // up wins over down
      key_stroke(STROKE_BOTH, 0, '0, 1, 100, 1'b1);
      // all column lines low picks column 0
      key_stroke(STROKE_MATRIX, 0, 7'h7F, 1, 100, 1'b1);
      key_stroke(STROKE_MATRIX, 3, 7'h40, 2, 100, 1'b1);
      // mute key long, then short as a plain matrix key
      key_stroke(STROKE_MATRIX, ROWS - 1, 7'h01, 3, 100, 1'b1);
      key_stroke(STROKE_MATRIX, ROWS - 1, 7'h01, 1, 100, 1'b1);
      // empty corner cell
      key_stroke(STROKE_MATRIX, ROWS - 1, 7'h40, 2, 100, 1'b1);
      key_stroke(STROKE_MATRIX, 4, 7'h21, 1, 100, 1'b1);
      // a report left untaken blocks the next press
      key_stroke(STROKE_DOWN, 0, '0, 1, 10, 1'b1);
      key_stroke(STROKE_MATRIX, 1, 7'h08, 2, 10, 1'b0);
   endtask

   // press counter saturates, register extremes
   task automatic test_counter_limits();
      set_config(8'd254, 8'd255, 8'd255);
      key_stroke(STROKE_UP, 0, '0, 260, 100, 1'b1);
      // silent buzzer, threshold of one
      set_config(8'd1, 8'd1, 8'd0);
      key_stroke(STROKE_DOWN, 0, '0, 1, 100, 1'b1);
      key_stroke(STROKE_DOWN, 0, '0, 2, 100, 1'b1);
   endtask

   // result side held off long enough to fill the block, then a drained pause
   task automatic test_backpressure();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_config(8'd2, 8'd4, 8'd6);
      hold_req = 80;
      key_stroke(STROKE_MATRIX, 1, 7'h04, 2, 50, 1'b1);
      key_stroke(STROKE_UP, 0, '0, 3, 50, 1'b1);
      wait_drained();
      key_stroke(STROKE_DOWN, 0, '0, 1, 50, 1'b1);
   endtask

   // random strokes and line noise under four idle mixes
   task automatic test_random_traffic();
      int idle_mix[4];
      int stall_mix[4];
      int phase_start;
      int pick;
      int hold_cap;
      int col;
      logic [CNT_W-1:0] threshold;
      logic [CNT_W-1:0] lockout;
      logic [CNT_W-1:0] beep;
      logic [COL_SENSE_W-1:0] col_bit;
      logic [COL_SENSE_W-1:0] low_mask;
      kpl_req_type noise;
      stroke_type kind;
      idle_mix  = '{0, 68, 0, 23};
      stall_mix = '{0, 0, 68, 23};
      for (int p = 0; p < 4; p++) begin
         threshold = (p == 2) ? 8'd254 : CNT_W'($urandom_range(1, 5));
         lockout   = ($urandom_range(3) == 0) ? 8'd0 : CNT_W'($urandom_range(1, 10));
         case ($urandom_range(3))
            0:       beep = 8'd0;
            1:       beep = 8'd255;
            default: beep = CNT_W'($urandom_range(1, 30));
         endcase
         set_config(threshold, lockout, beep);
         req_idle_pct  = idle_mix[p];
         rsp_stall_pct = stall_mix[p];
         phase_start   = ticks_sent;
         while (ticks_sent - phase_start < PHASE_TICKS) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
               // raw line noise, broken sequences
               repeat ($urandom_range(1, 12)) begin
                  noise = REQ_W'($urandom);
                  send_tick(noise);
               end
            end else begin
               kind = (pick < 60) ? STROKE_MATRIX : (pick < 75) ? STROKE_UP :
                      (pick < 90) ? STROKE_DOWN : STROKE_BOTH;
               col      = $urandom_range(0, COLS - 1);
               col_bit  = COL_SENSE_W'(1) << col;
               low_mask = (COL_SENSE_W'($urandom) & ~(col_bit - 1'b1)) | col_bit;
               hold_cap = (kind == STROKE_MATRIX) ? 6 : 24;
               if (kp_cfg.long_threshold + 2 < hold_cap)
                  hold_cap = kp_cfg.long_threshold + 2;
               key_stroke(kind, $urandom_range(0, ROWS - 1), low_mask,
                          $urandom_range(1, hold_cap), $urandom_range(10, 90),
                          $urandom_range(3) != 0);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.col_sense = COL_IDLE;
      req_if.up_key    = 1'b0;
      req_if.down_key  = 1'b0;
      req_if.host_take = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_LONG_THRESHOLD;
      csr_wdata        = '0;
      mismatches       = 0;
      ticks_sent       = 0;
      reports_made     = 0;
      csr_writes       = 0;
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      hold_req         = 0;
      kp_state           = '0;
      kp_state.held_cols = COL_IDLE;
      kp_cfg.long_threshold = LONG_THRESHOLD_RST;
      kp_cfg.lockout_ticks  = LOCKOUT_TICKS_RST;
      kp_cfg.beep_ticks     = BEEP_TICKS_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_report_kinds();
      test_counter_limits();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("run: %0d ticks, %0d key reports, %0d register writes",
               ticks_sent, reports_made, csr_writes);
      $display("run: all report kinds, counter saturation, long result hold, four idle mixes");
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
hdl/kpl_pkg.sv
hdl/kpl_req_if.sv
hdl/kpl_rsp_if.sv
hdl/kpl_csr.sv
hdl/kpl_scan.sv
hdl/keypad_scanner_long_press.sv
verif/tb_top.sv
